[src/sgpid_pkg.sv]
// ----------------------------------------------------------------------------
// sgpid_pkg: shared types and constants of the shift-gain PID controller
// Field widths, register indexes, command codes and the history cell control.
// ----------------------------------------------------------------------------
`default_nettype none

package sgpid_pkg;

  // Field widths
  localparam int TEMP_W  = 14;  // target and measured samples
  localparam int ERR_W   = 15;  // error and derivative
  localparam int INTEG_W = 16;  // integral accumulator
  localparam int DRIVE_W = 16;  // drive output and max_output
  localparam int SHIFT_W = 4;   // gain shift registers
  localparam int CFG_W   = 16;  // widest configuration register
  localparam int CFG_IDX_W = 2;

  // Wide sum: integral (16 bits) shifted by up to 15, plus two 15-bit terms
  localparam int SUM_W   = 34;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_SHIFT  = 2'd0,
    REG_INTEG_SHIFT = 2'd1,
    REG_DERIV_SHIFT = 2'd2,
    REG_MAX_OUTPUT  = 2'd3
  } cfg_reg_t;

  // Command codes
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Reset values of the registers
  localparam logic [SHIFT_W-1:0] PROP_SHIFT_RST  = 4'd13;
  localparam logic [SHIFT_W-1:0] INTEG_SHIFT_RST = 4'd3;
  localparam logic [SHIFT_W-1:0] DERIV_SHIFT_RST = 4'd13;
  localparam logic [DRIVE_W-1:0] MAX_OUTPUT_RST  = 16'hFFFF;

  // Control shared by the history cells and the arithmetic stage
  typedef struct packed {
    logic update;  // accepted control update beat
    logic clear;   // accepted clear beat
  } step_ctrl_t;

endpackage

`default_nettype wire

[src/sgpid_cell.sv]
// ----------------------------------------------------------------------------
// sgpid_cell: one stage of the measured-sample delay line
// Holds one past sample; takes its neighbor's sample on every update beat and
// zeroes on a clear beat.
// ----------------------------------------------------------------------------
`default_nettype none

module sgpid_cell
  import sgpid_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire step_ctrl_t               ctrl,
  input  wire logic signed [TEMP_W-1:0] sample_in,
  output logic signed [TEMP_W-1:0]      sample_out
);

  logic signed [TEMP_W-1:0] sample;

  // Shift on update, zero on clear or reset
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      sample <= '0;
    end else if (ctrl.update) begin
      sample <= sample_in;
    end
  end

  assign sample_out = sample;

endmodule

`default_nettype wire

[src/sgpid_calc.sv]
// ----------------------------------------------------------------------------
// sgpid_calc: PID sum, drive clamp and anti-windup integral
// Forms the shifted-gain sum for one update beat, clamps it to the drive range
// and keeps the saturating integral register.
// ----------------------------------------------------------------------------
`default_nettype none

module sgpid_calc
  import sgpid_pkg::*;
#(
  parameter int POST_SHIFT = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire step_ctrl_t                ctrl,
  input  wire logic signed [TEMP_W-1:0]  target_value,
  input  wire logic signed [TEMP_W-1:0]  measured_value,
  input  wire logic signed [TEMP_W-1:0]  delayed_value,
  input  wire logic [SHIFT_W-1:0]        prop_shift,
  input  wire logic [SHIFT_W-1:0]        integ_shift,
  input  wire logic [SHIFT_W-1:0]        deriv_shift,
  input  wire logic [DRIVE_W-1:0]        max_output,
  output logic [DRIVE_W-1:0]             drive_value
);

  logic signed [INTEG_W-1:0] integral;
  logic signed [INTEG_W-1:0] integral_next;
  logic signed [ERR_W-1:0]   error;
  logic signed [ERR_W-1:0]   derivative;
  logic signed [SUM_W-1:0]   p_term;
  logic signed [SUM_W-1:0]   i_term;
  logic signed [SUM_W-1:0]   d_term;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SUM_W-1:0]   scaled;
  logic signed [SUM_W-1:0]   max_wide;
  logic signed [INTEG_W:0]   integ_add;
  logic                      take;

  // Error and delayed derivative
  assign error      = ERR_W'(target_value) - ERR_W'(measured_value);
  assign derivative = ERR_W'(delayed_value) - ERR_W'(measured_value);

  // Gain shifts and post-divide (arithmetic shift rounds toward minus infinity)
  assign p_term   = SUM_W'(error) <<< prop_shift;
  assign i_term   = SUM_W'(integral) <<< integ_shift;
  assign d_term   = SUM_W'(derivative) <<< deriv_shift;
  assign sum      = p_term + i_term + d_term;
  assign scaled   = sum >>> POST_SHIFT;
  assign max_wide = $signed({{(SUM_W-DRIVE_W){1'b0}}, max_output});

  // Anti-windup: integrate inside range, or when the error pulls back toward it
  assign take = (!scaled[SUM_W-1] && scaled <= max_wide)
             || (scaled > 0 && error < 0)
             || (scaled[SUM_W-1] && error > 0);

  assign integ_add = (INTEG_W+1)'(integral) + (INTEG_W+1)'(error);

  always_comb begin
    integral_next = integral;
    if (ctrl.clear) begin
      integral_next = '0;
    end else if (ctrl.update && take) begin
      if (integ_add > (INTEG_W+1)'(32767)) begin
        integral_next = INTEG_W'(16'sh7FFF);
      end else if (integ_add < -(INTEG_W+1)'(32768)) begin
        integral_next = INTEG_W'(16'sh8000);
      end else begin
        integral_next = integ_add[INTEG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral <= '0;
    end else begin
      integral <= integral_next;
    end
  end

  // Drive clamp to 0..max_output
  always_comb begin
    if (scaled[SUM_W-1]) begin
      drive_value = '0;
    end else if (scaled > max_wide) begin
      drive_value = max_output;
    end else begin
      drive_value = scaled[DRIVE_W-1:0];
    end
  end

endmodule

`default_nettype wire

[src/shift_gain_pid_controller_unit.sv]
// ----------------------------------------------------------------------------
// shift_gain_pid_controller_unit: shift-gain PID controller with anti-windup
// Top level: configuration registers, sample delay line, arithmetic stage and
// output register.
// ----------------------------------------------------------------------------
// Takes one beat per clock when the output side keeps up; each beat's drive
// appears in the output register in the cycle after acceptance. The whole
// update (error, gains, sum, clamp and integral update) runs in the cycle the
// beat is taken, since the integral of one beat feeds the next. Past samples
// sit in a chain of DELAY_DEPTH cells that shifts on every update beat, so the
// derivative uses the sample from DELAY_DEPTH updates earlier. A clear beat
// zeroes the chain and the integral at once and returns drive 0; no clearing
// pass is needed after reset. Configuration writes take effect at the next
// beat.
`default_nettype none

module shift_gain_pid_controller_unit
  import sgpid_pkg::*;
#(
  parameter int DELAY_DEPTH = 40,
  parameter int POST_SHIFT  = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // Configuration write port
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_data,
  // Input channel
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     command,
  input  wire logic signed [TEMP_W-1:0] target_value,
  input  wire logic signed [TEMP_W-1:0] measured_value,
  // Output channel
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [DRIVE_W-1:0]            drive
);

  logic [SHIFT_W-1:0]       prop_shift;
  logic [SHIFT_W-1:0]       integ_shift;
  logic [SHIFT_W-1:0]       deriv_shift;
  logic [DRIVE_W-1:0]       max_output;
  step_ctrl_t               ctrl;
  logic                     in_beat;
  logic signed [TEMP_W-1:0] chain [DELAY_DEPTH+1];
  logic [DRIVE_W-1:0]       drive_value;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_shift  <= PROP_SHIFT_RST;
      integ_shift <= INTEG_SHIFT_RST;
      deriv_shift <= DERIV_SHIFT_RST;
      max_output  <= MAX_OUTPUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PROP_SHIFT:  prop_shift  <= cfg_data[SHIFT_W-1:0];
        REG_INTEG_SHIFT: integ_shift <= cfg_data[SHIFT_W-1:0];
        REG_DERIV_SHIFT: deriv_shift <= cfg_data[SHIFT_W-1:0];
        REG_MAX_OUTPUT:  max_output  <= cfg_data[DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake: free output register or one being drained
  assign in_ready    = !out_valid || out_ready;
  assign in_beat     = in_valid && in_ready;
  assign ctrl.update = in_beat && (command == CMD_UPDATE);
  assign ctrl.clear  = in_beat && (command == CMD_CLEAR);

  // Delay line of past measured samples
  assign chain[0] = measured_value;

  for (genvar i = 0; i < DELAY_DEPTH; i++) begin : g_cell
    sgpid_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .sample_in  (chain[i]),
      .sample_out (chain[i+1])
    );
  end

  // PID arithmetic and integral
  sgpid_calc #(
    .POST_SHIFT (POST_SHIFT)
  ) u_calc (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .target_value   (target_value),
    .measured_value (measured_value),
    .delayed_value  (chain[DELAY_DEPTH]),
    .prop_shift     (prop_shift),
    .integ_shift    (integ_shift),
    .deriv_shift    (deriv_shift),
    .max_output     (max_output),
    .drive_value    (drive_value)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_beat) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      drive <= ctrl.clear ? '0 : drive_value;
    end
  end

endmodule

`default_nettype wire
